@@ design/tcld_pkg.sv @@
`default_nettype none
package tcld_pkg;

    localparam int LINE_CAPACITY_DEF = 64;
    localparam int NUM_WORDS = 8;

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [19:0] DIGIT_SAT = 20'd1000000;
    localparam logic [31:0] TIMEOUT_RST = 32'd500;
    localparam logic [9:0] LIMIT_RST = 10'd100;

    typedef enum logic [0:0] {
        REG_TIMEOUT = 1'b0,
        REG_LIMIT   = 1'b1
    } reg_idx_t;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_RC      = 3'd1,
        EV_ACTION  = 3'd2,
        EV_HELP    = 3'd3,
        EV_UNKNOWN = 3'd4,
        EV_TOOLONG = 3'd5
    } event_t;

    typedef enum logic [2:0] {
        ACT_NONE    = 3'd0,
        ACT_HELLO   = 3'd1,
        ACT_TAKEOFF = 3'd2,
        ACT_MISSION = 3'd3,
        ACT_LAND    = 3'd4,
        ACT_ABORT   = 3'd5,
        ACT_STOP    = 3'd6
    } action_t;

    typedef enum logic [2:0] {
        W_RC      = 3'd0,
        W_MISSION = 3'd1,
        W_STOP    = 3'd2,
        W_HELLO   = 3'd3,
        W_TAKEOFF = 3'd4,
        W_LAND    = 3'd5,
        W_ABORT   = 3'd6,
        W_HELP    = 3'd7
    } word_t;

    typedef struct packed {
        event_t          ev;
        action_t         act;
        logic [3:0]      pad;
        logic            set_rc;
        logic            zero_tg;
        logic            touch;
    } dec_t;

    function automatic logic [63:0] word_text(input word_t w);
        logic [63:0] s;
        unique case (w)
            W_RC:      s = 64'("rc");
            W_MISSION: s = 64'("mission");
            W_STOP:    s = 64'("stop");
            W_HELLO:   s = 64'("hello");
            W_TAKEOFF: s = 64'("takeoff");
            W_LAND:    s = 64'("land");
            W_ABORT:   s = 64'("abort");
            W_HELP:    s = 64'("help");
            default:   s = '0;
        endcase
        return s;
    endfunction

    function automatic logic [2:0] word_len(input word_t w);
        logic [2:0] l;
        unique case (w)
            W_RC:                        l = 3'd2;
            W_MISSION, W_TAKEOFF:        l = 3'd7;
            W_STOP, W_LAND, W_HELP:      l = 3'd4;
            W_HELLO, W_ABORT:            l = 3'd5;
            default:                     l = 3'd0;
        endcase
        return l;
    endfunction

    // character i of word w, valid for i < length
    function automatic logic [7:0] word_char(input word_t w, input logic [2:0] i);
        logic [63:0] s;
        logic [2:0]  k;
        s = word_text(w);
        k = 3'(word_len(w) - 3'd1 - i);
        return s[{k, 3'b000} +: 8];
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

endpackage
`default_nettype wire

@@ design/text_command_line_decoder_top.sv @@
`default_nettype none
// Text command line decoder. Each input word (a received byte or a time poll)
// yields exactly one output word. A plain byte, CR, empty LF or poll goes
// straight to the emit state; a line feed ending a stored line passes through
// the run and finish states first, the line store being walked one entry per
// cycle through its single read port. Stick targets read as zero once older
// than timeout_ms. Config writes are always ready and must be made while idle.
module text_command_line_decoder_top #(
    parameter int LINE_CAPACITY = tcld_pkg::LINE_CAPACITY_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               action,
    input  wire logic [7:0]         data_byte,
    input  wire logic [31:0]        now_ms,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [2:0]              event_res,
    output logic [2:0]              action_code,
    output logic [3:0]              pad_id,
    output logic signed [10:0]      left_right,
    output logic signed [10:0]      fwd_back,
    output logic signed [10:0]      up_down,
    output logic signed [10:0]      yaw_rate,
    output logic                    fresh,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [0:0]         cfg_index,
    input  wire logic [31:0]        cfg_data
);
    import tcld_pkg::*;

    localparam int AW = $clog2(LINE_CAPACITY);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_RUN    = 4'b0010,
        ST_FINISH = 4'b0100,
        ST_EMIT   = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    logic [AW-1:0]      count_reg, count_next;
    logic [AW-1:0]      rd_idx_reg, rd_idx_next;
    logic               dv_reg, dv_next;
    logic [31:0]        now_reg, now_next;
    event_t             ev_reg, ev_next;
    action_t            act_reg, act_next;
    logic [3:0]         pad_reg, pad_next;
    logic signed [10:0] tg_reg [4];
    logic signed [10:0] tg_next [4];
    logic [31:0]        last_reg, last_next;
    logic               has_reg, has_next;
    logic [31:0]        timeout_reg;
    logic [9:0]         limit_reg;
    logic               ov_reg, ov_next;

    logic               in_acc;
    logic               wr_en;
    logic [7:0]         rdata;
    logic               p_start;
    logic               p_step;
    dec_t               dec;
    logic signed [10:0] vals [4];
    logic               fr;

    assign in_stall = (state_reg != ST_IDLE) || (ov_reg && out_stall);
    assign in_acc = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    tcld_ram #(
        .WIDTH(8),
        .DEPTH(LINE_CAPACITY)
    ) u_line_ram (
        .clk(clk),
        .we(wr_en),
        .waddr(count_reg),
        .wdata(data_byte),
        .raddr(rd_idx_reg),
        .rdata(rdata)
    );

    tcld_parser #(
        .AW(AW)
    ) u_parser (
        .clk(clk),
        .rst_n(rst_n),
        .start(p_start),
        .step(p_step),
        .ch(rdata),
        .limit(limit_reg),
        .dec(dec),
        .vals(vals)
    );

    assign fr = has_reg && ((now_reg - last_reg) <= timeout_reg);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        rd_idx_next = rd_idx_reg;
        dv_next = 1'b0;
        now_next = now_reg;
        ev_next = ev_reg;
        act_next = act_reg;
        pad_next = pad_reg;
        tg_next = tg_reg;
        last_next = last_reg;
        has_next = has_reg;
        ov_next = ov_reg && out_stall;
        wr_en = 1'b0;
        p_start = 1'b0;
        p_step = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    now_next = now_ms;
                    ev_next = EV_NONE;
                    act_next = ACT_NONE;
                    pad_next = 4'd0;
                    state_next = ST_EMIT;
                    if (!action && data_byte != CH_CR)
                    begin
                        if (data_byte == CH_LF)
                        begin
                            if (count_reg != '0)
                            begin
                                p_start = 1'b1;
                                rd_idx_next = '0;
                                state_next = ST_RUN;
                            end
                        end
                        else if (count_reg < AW'(LINE_CAPACITY - 1))
                        begin
                            wr_en = 1'b1;
                            count_next = count_reg + AW'(1);
                        end
                        else
                        begin
                            count_next = '0;
                            ev_next = EV_TOOLONG;
                        end
                    end
                end
            end
            ST_RUN:
            begin
                p_step = dv_reg && (rdata != CH_NUL);
                if ((dv_reg && rdata == CH_NUL) || (!dv_reg && rd_idx_reg == count_reg))
                begin
                    state_next = ST_FINISH;
                end
                else if (rd_idx_reg < count_reg)
                begin
                    rd_idx_next = rd_idx_reg + AW'(1);
                    dv_next = 1'b1;
                end
            end
            ST_FINISH:
            begin
                ev_next = dec.ev;
                act_next = dec.act;
                pad_next = dec.pad;
                count_next = '0;
                if (dec.set_rc)
                begin
                    tg_next = vals;
                end
                if (dec.zero_tg)
                begin
                    for (int k = 0; k < 4; k++)
                    begin
                        tg_next[k] = '0;
                    end
                end
                if (dec.set_rc || dec.touch)
                begin
                    last_next = now_reg;
                    has_next = 1'b1;
                end
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                ov_next = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            rd_idx_reg <= '0;
            dv_reg <= 1'b0;
            for (int k = 0; k < 4; k++)
            begin
                tg_reg[k] <= '0;
            end
            last_reg <= '0;
            has_reg <= 1'b0;
            timeout_reg <= TIMEOUT_RST;
            limit_reg <= LIMIT_RST;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            rd_idx_reg <= rd_idx_next;
            dv_reg <= dv_next;
            tg_reg <= tg_next;
            last_reg <= last_next;
            has_reg <= has_next;
            ov_reg <= ov_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (reg_idx_t'(cfg_index))
                    REG_TIMEOUT: timeout_reg <= cfg_data;
                    REG_LIMIT:   limit_reg <= cfg_data[9:0];
                    default:     timeout_reg <= timeout_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg <= now_next;
        ev_reg <= ev_next;
        act_reg <= act_next;
        pad_reg <= pad_next;
        if (state_reg == ST_EMIT)
        begin
            event_res <= ev_reg;
            action_code <= act_reg;
            pad_id <= pad_reg;
            left_right <= fr ? tg_reg[0] : '0;
            fwd_back <= fr ? tg_reg[1] : '0;
            up_down <= fr ? tg_reg[2] : '0;
            yaw_rate <= fr ? tg_reg[3] : '0;
            fresh <= fr;
        end
    end

    assign out_valid = ov_reg;

    a_run_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (count_reg != '0))
        else $error("line walk with empty line");

    a_stale_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !fresh) |->
            (left_right == '0 && fwd_back == '0 && up_down == '0 && yaw_rate == '0))
        else $error("stale targets not zeroed");

    a_action_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && event_res != EV_ACTION) |-> (action_code == ACT_NONE && pad_id == 4'd0))
        else $error("action fields set without action event");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> !(ov_reg && out_stall))
        else $error("output word overwritten");

endmodule
`default_nettype wire

@@ design/tcld_ram.sv @@
`default_nettype none
module tcld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

@@ design/tcld_parser.sv @@
`default_nettype none
module tcld_parser #(
    parameter int AW = 6
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic               step,
    input  wire logic [7:0]         ch,
    input  wire logic [9:0]         limit,
    output tcld_pkg::dec_t          dec,
    output logic signed [10:0]      vals [4]
);
    import tcld_pkg::*;

    typedef enum logic [5:0] {
        PS_WAIT  = 6'b000001,
        PS_START = 6'b000010,
        PS_SIGN  = 6'b000100,
        PS_DIG   = 6'b001000,
        PS_TRAIL = 6'b010000,
        PS_FAIL  = 6'b100000
    } pstate_t;

    pstate_t                ps_reg, ps_next;
    logic [AW-1:0]          pos_reg, pos_next;
    logic [NUM_WORDS-1:0]   ok_reg, ok_next;
    logic                   mis_reg, mis_next;
    logic [1:0]             idx_reg, idx_next;
    logic                   neg_reg, neg_next;
    logic [19:0]            mag_reg, mag_next;
    logic signed [10:0]     val_reg [4];
    logic signed [10:0]     val_next [4];

    logic [23:0]            prod;
    logic [19:0]            grown;
    logic [19:0]            first;
    logic                   last_int;
    logic                   sp;
    logic                   dg;
    logic                   sg;

    function automatic logic signed [10:0] clamp(input logic [19:0] m, input logic n,
                                                input logic [9:0] lim);
        logic [10:0] a;
        a = (m > 20'(lim)) ? {1'b0, lim} : m[10:0];
        return n ? -$signed(a) : $signed(a);
    endfunction

    always_comb
    begin
        prod = {mag_reg, 3'b000} + {3'b000, mag_reg, 1'b0} + 24'(ch[3:0]);
        grown = (prod > 24'(DIGIT_SAT)) ? DIGIT_SAT : prod[19:0];
        first = 20'(ch[3:0]);
        last_int = mis_reg ? (idx_reg == 2'd0) : (idx_reg == 2'd3);
        sp = is_space(ch);
        dg = is_digit(ch);
        sg = (ch == "+") || (ch == "-");

        ps_next = ps_reg;
        pos_next = pos_reg;
        ok_next = ok_reg;
        mis_next = mis_reg;
        idx_next = idx_reg;
        neg_next = neg_reg;
        mag_next = mag_reg;
        val_next = val_reg;

        if (start)
        begin
            ps_next = PS_WAIT;
            pos_next = '0;
            ok_next = '1;
            mis_next = 1'b0;
            idx_next = '0;
            neg_next = 1'b0;
            mag_next = '0;
        end
        else if (step)
        begin
            pos_next = pos_reg + AW'(1);
            for (int w = 0; w < NUM_WORDS; w++)
            begin
                if (pos_reg < AW'(word_len(word_t'(w))))
                begin
                    ok_next[w] = ok_reg[w] && (ch == word_char(word_t'(w), pos_reg[2:0]));
                end
                else
                begin
                    ok_next[w] = 1'b0;
                end
            end
            if (pos_reg == AW'(1) && ok_reg[W_RC] && ch == "c")
            begin
                ps_next = PS_START;
                mis_next = 1'b0;
            end
            else if (pos_reg == AW'(6) && ok_reg[W_MISSION] && ch == "n")
            begin
                ps_next = PS_START;
                mis_next = 1'b1;
            end
            else
            begin
                unique case (ps_reg)
                    PS_WAIT, PS_FAIL:
                    begin
                    end
                    PS_START:
                    begin
                        if (sp)
                        begin
                        end
                        else if (sg)
                        begin
                            ps_next = PS_SIGN;
                            neg_next = (ch == "-");
                        end
                        else if (dg)
                        begin
                            ps_next = PS_DIG;
                            mag_next = first;
                            val_next[idx_reg] = clamp(first, neg_reg, limit);
                        end
                        else
                        begin
                            ps_next = PS_FAIL;
                        end
                    end
                    PS_SIGN:
                    begin
                        if (dg)
                        begin
                            ps_next = PS_DIG;
                            mag_next = first;
                            val_next[idx_reg] = clamp(first, neg_reg, limit);
                        end
                        else
                        begin
                            ps_next = PS_FAIL;
                        end
                    end
                    PS_DIG:
                    begin
                        if (dg)
                        begin
                            mag_next = grown;
                            val_next[idx_reg] = clamp(grown, neg_reg, limit);
                        end
                        else if (last_int)
                        begin
                            ps_next = sp ? PS_TRAIL : PS_FAIL;
                        end
                        else
                        begin
                            idx_next = idx_reg + 2'd1;
                            neg_next = 1'b0;
                            if (sp)
                            begin
                                ps_next = PS_START;
                            end
                            else if (sg)
                            begin
                                ps_next = PS_SIGN;
                                neg_next = (ch == "-");
                            end
                            else
                            begin
                                ps_next = PS_FAIL;
                            end
                        end
                    end
                    PS_TRAIL:
                    begin
                        if (!sp)
                        begin
                            ps_next = PS_FAIL;
                        end
                    end
                    default:
                    begin
                        ps_next = PS_FAIL;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ps_reg <= PS_WAIT;
            pos_reg <= '0;
            ok_reg <= '0;
            mis_reg <= 1'b0;
            idx_reg <= '0;
        end
        else
        begin
            ps_reg <= ps_next;
            pos_reg <= pos_next;
            ok_reg <= ok_next;
            mis_reg <= mis_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        mag_reg <= mag_next;
        val_reg <= val_next;
    end

    logic num_ok;
    logic rc_hit;
    logic mis_hit;

    function automatic logic hit(input logic [NUM_WORDS-1:0] ok, input word_t w,
                                 input logic [AW-1:0] n);
        return ok[w] && (n == AW'(word_len(w)));
    endfunction

    always_comb
    begin
        num_ok = (ps_reg == PS_DIG) || (ps_reg == PS_TRAIL);
        rc_hit = !mis_reg && num_ok && (idx_reg == 2'd3);
        mis_hit = mis_reg && num_ok && !neg_reg && (mag_reg >= 20'd1) && (mag_reg <= 20'd8);
        dec = '{ev: EV_UNKNOWN, act: ACT_NONE, pad: 4'd0,
                set_rc: 1'b0, zero_tg: 1'b0, touch: 1'b0};
        if (rc_hit)
        begin
            dec.ev = EV_RC;
            dec.set_rc = 1'b1;
        end
        else if (hit(ok_reg, W_STOP, pos_reg))
        begin
            dec.ev = EV_ACTION;
            dec.act = ACT_STOP;
            dec.zero_tg = 1'b1;
            dec.touch = 1'b1;
        end
        else if (hit(ok_reg, W_HELLO, pos_reg))
        begin
            dec.ev = EV_ACTION;
            dec.act = ACT_HELLO;
        end
        else if (hit(ok_reg, W_TAKEOFF, pos_reg))
        begin
            dec.ev = EV_ACTION;
            dec.act = ACT_TAKEOFF;
            dec.zero_tg = 1'b1;
        end
        else if (mis_hit)
        begin
            dec.ev = EV_ACTION;
            dec.act = ACT_MISSION;
            dec.pad = mag_reg[3:0];
            dec.zero_tg = 1'b1;
        end
        else if (hit(ok_reg, W_LAND, pos_reg))
        begin
            dec.ev = EV_ACTION;
            dec.act = ACT_LAND;
            dec.zero_tg = 1'b1;
        end
        else if (hit(ok_reg, W_ABORT, pos_reg))
        begin
            dec.ev = EV_ACTION;
            dec.act = ACT_ABORT;
            dec.zero_tg = 1'b1;
        end
        else if (hit(ok_reg, W_HELP, pos_reg))
        begin
            dec.ev = EV_HELP;
        end
    end

    assign vals = val_reg;

endmodule
`default_nettype wire
